[src/gs3_pkg.sv]
// ----------------------------------------------------------------------------
// gs3_pkg
// Shared widths, latencies, row types and rounding helpers for the 3x3
// modified Gram-Schmidt orthonormaliser.
// ----------------------------------------------------------------------------
package gs3_pkg;

    // Fixed-point formats
    localparam int unsigned IN_W          = 16;
    localparam int unsigned OUT_W         = 16;
    localparam int unsigned GUARD_BITS    = 8;
    localparam int unsigned QF_BITS       = 30;
    localparam int unsigned NORM_EXTRA    = 6;
    localparam int unsigned OUT_FRAC_BITS = 14;

    // Internal widths
    localparam int unsigned VW      = 28;              // working row element
    localparam int unsigned QW      = 32;              // finished row element
    localparam int unsigned DW      = 28;              // projection coefficient
    localparam int unsigned PW      = 60;              // lane product
    localparam int unsigned ACC_W   = 64;              // dot-product sum
    localparam int unsigned SQ_W    = 2 * VW;          // lane square
    localparam int unsigned SUM_W   = SQ_W + 2;        // sum of three squares
    localparam int unsigned N2_W    = 50;              // squared norm
    localparam int unsigned SQ_IN_W = N2_W + 2 * NORM_EXTRA;
    localparam int unsigned ROOT_W  = SQ_IN_W / 2;
    localparam int unsigned DVD_W   = 63;              // dividend / remainder
    localparam int unsigned QUO_W   = 31;              // quotient magnitude

    // Unit latencies in cycles
    localparam int unsigned LAT_PROJ = 5;
    localparam int unsigned LAT_SQRT = ROOT_W;
    localparam int unsigned LAT_DIV  = QUO_W;
    localparam int unsigned LAT_NORM = LAT_SQRT + LAT_DIV + 4;

    // Output clamp
    localparam logic signed [63:0] OUT_HI = 64'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [63:0] OUT_LO = -OUT_HI;

    typedef logic signed [VW-1:0] velem_t;
    typedef velem_t [2:0]         vrow_t;
    typedef logic signed [QW-1:0] qelem_t;
    typedef qelem_t [2:0]         qrow_t;

    // Round to nearest, ties away from zero, then shift right
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int unsigned sh);
        logic [63:0] u;
        logic [63:0] r;
        u = x[63] ? (~x + 64'd1) : x;
        r = (u + (64'd1 << (sh - 1))) >> sh;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    // Magnitude of a working element
    function automatic logic [VW-1:0] mag_v(input velem_t x);
        return x[VW-1] ? VW'(-x) : VW'(x);
    endfunction

    // Input entry to working element
    function automatic velem_t to_v(input logic signed [IN_W-1:0] x);
        return VW'(x) <<< GUARD_BITS;
    endfunction

    // Finished element to saturated output
    function automatic logic signed [OUT_W-1:0] fmt_out(input qelem_t q);
        logic signed [63:0] t;
        t = rnd_shift(64'(q), QF_BITS - OUT_FRAC_BITS);
        if (t > OUT_HI) begin
            t = OUT_HI;
        end else if (t < OUT_LO) begin
            t = OUT_LO;
        end
        return t[OUT_W-1:0];
    endfunction

endpackage

[src/gram_schmidt_orthonormalize_3x3.sv]
// Path from an accepted request to m_valid: input register, three row normalisers, two
// projection steps, output register. Throughput: one matrix per cycle while the output
// buffer has room; every unit, including the 31-stage square root and the 31-stage divider
// lanes, is fully pipelined. A two-entry output buffer decouples m_ready.
// Reset (aresetn low, synchronous) empties the valid pipeline and the output buffer.
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalize_3x3
// Modified Gram-Schmidt orthonormalisation of a 3x3 Q3.13 matrix into Q1.14
// rows with a degenerate flag for rows of zero norm.
// ----------------------------------------------------------------------------
module gram_schmidt_orthonormalize_3x3 (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_in_r0c0,
    input  logic signed [15:0] s_in_r0c1,
    input  logic signed [15:0] s_in_r0c2,
    input  logic signed [15:0] s_in_r1c0,
    input  logic signed [15:0] s_in_r1c1,
    input  logic signed [15:0] s_in_r1c2,
    input  logic signed [15:0] s_in_r2c0,
    input  logic signed [15:0] s_in_r2c1,
    input  logic signed [15:0] s_in_r2c2,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_r0c0,
    output logic signed [15:0] m_out_r0c1,
    output logic signed [15:0] m_out_r0c2,
    output logic signed [15:0] m_out_r1c0,
    output logic signed [15:0] m_out_r1c1,
    output logic signed [15:0] m_out_r1c2,
    output logic signed [15:0] m_out_r2c0,
    output logic signed [15:0] m_out_r2c1,
    output logic signed [15:0] m_out_r2c2,
    output logic               m_degenerate
);

    localparam int unsigned VW    = gs3_pkg::VW;
    localparam int unsigned QW    = gs3_pkg::QW;
    localparam int unsigned OUT_W = gs3_pkg::OUT_W;
    localparam int unsigned LN    = gs3_pkg::LAT_NORM;
    localparam int unsigned LP    = gs3_pkg::LAT_PROJ;
    localparam int unsigned LAT   = 3 * LN + 2 * LP + 2;
    localparam int unsigned SKID_DEPTH = 2;

    typedef struct packed {
        logic [8:0][OUT_W-1:0] ent;
        logic                  degen;
    } res_t;

    logic             en;
    logic [LAT-1:0]   vld_reg;
    gs3_pkg::vrow_t   vin_reg [3];
    gs3_pkg::vrow_t   v1d, v2d, v1p, v2p, v2pd, v2pp;
    gs3_pkg::qrow_t   q0, q1, q2, q0d, q1d;
    logic             z0, z1, z2, z0d, z1d;
    gs3_pkg::qrow_t   qa [3];
    res_t             fmt_reg;
    res_t             fifo_reg [SKID_DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    // pipeline advances unless the output buffer is full
    assign en      = (cnt_reg != 2'(SKID_DEPTH));
    assign s_ready = en;

    // valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // input register, entries scaled into working rows
    always_ff @(posedge aclk) begin
        if (en) begin
            vin_reg[0] <= {gs3_pkg::to_v(s_in_r0c2), gs3_pkg::to_v(s_in_r0c1),
                           gs3_pkg::to_v(s_in_r0c0)};
            vin_reg[1] <= {gs3_pkg::to_v(s_in_r1c2), gs3_pkg::to_v(s_in_r1c1),
                           gs3_pkg::to_v(s_in_r1c0)};
            vin_reg[2] <= {gs3_pkg::to_v(s_in_r2c2), gs3_pkg::to_v(s_in_r2c1),
                           gs3_pkg::to_v(s_in_r2c0)};
        end
    end

    // row 0
    gs3_norm u_norm0 (.aclk(aclk), .en(en), .v(vin_reg[0]), .q(q0), .zero(z0));

    gs3_delay #(.W(6 * VW), .N(LN)) u_dly_v12 (
        .aclk (aclk), .en (en),
        .din  ({vin_reg[1], vin_reg[2]}),
        .dout ({v1d, v2d})
    );

    // rows 1 and 2 lose their projection onto row 0 side by side
    gs3_proj u_proj10 (.aclk(aclk), .en(en), .q(q0), .v(v1d), .v_out(v1p));
    gs3_proj u_proj20 (.aclk(aclk), .en(en), .q(q0), .v(v2d), .v_out(v2p));

    // row 1
    gs3_norm u_norm1 (.aclk(aclk), .en(en), .v(v1p), .q(q1), .zero(z1));

    gs3_delay #(.W(3 * VW), .N(LN)) u_dly_v2 (
        .aclk (aclk), .en (en), .din (v2p), .dout (v2pd)
    );

    // row 2 against row 1, then normalise
    gs3_proj u_proj21 (.aclk(aclk), .en(en), .q(q1), .v(v2pd), .v_out(v2pp));
    gs3_norm u_norm2 (.aclk(aclk), .en(en), .v(v2pp), .q(q2), .zero(z2));

    // align finished rows with row 2
    gs3_delay #(.W(3 * QW + 1), .N(2 * LN + 2 * LP)) u_dly_q0 (
        .aclk (aclk), .en (en), .din ({q0, z0}), .dout ({q0d, z0d})
    );
    gs3_delay #(.W(3 * QW + 1), .N(LN + LP)) u_dly_q1 (
        .aclk (aclk), .en (en), .din ({q1, z1}), .dout ({q1d, z1d})
    );

    assign qa[0] = q0d;
    assign qa[1] = q1d;
    assign qa[2] = q2;

    // output rounding and saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    fmt_reg.ent[i * 3 + k] <= gs3_pkg::fmt_out(qa[i][k]);
                end
            end
            fmt_reg.degen <= z0d | z1d | z2;
        end
    end

    // two-entry output buffer
    assign push = en && vld_reg[LAT-1];
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= fmt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_valid      = (cnt_reg != '0);
    assign m_out_r0c0   = fifo_reg[rd_ptr_reg].ent[0];
    assign m_out_r0c1   = fifo_reg[rd_ptr_reg].ent[1];
    assign m_out_r0c2   = fifo_reg[rd_ptr_reg].ent[2];
    assign m_out_r1c0   = fifo_reg[rd_ptr_reg].ent[3];
    assign m_out_r1c1   = fifo_reg[rd_ptr_reg].ent[4];
    assign m_out_r1c2   = fifo_reg[rd_ptr_reg].ent[5];
    assign m_out_r2c0   = fifo_reg[rd_ptr_reg].ent[6];
    assign m_out_r2c1   = fifo_reg[rd_ptr_reg].ent[7];
    assign m_out_r2c2   = fifo_reg[rd_ptr_reg].ent[8];
    assign m_degenerate = fifo_reg[rd_ptr_reg].degen;

    // buffer occupancy stays within its depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(SKID_DEPTH))
        else $error("output buffer overfilled");

    // input only held off while results wait
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output buffer");

    // a stalled last stage keeps its request
    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && vld_reg[LAT-1]) |=> vld_reg[LAT-1])
        else $error("request dropped during stall");

    // degenerate flag comes with an all-zero row
    a_degen_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |->
        ((m_out_r0c0 == '0 && m_out_r0c1 == '0 && m_out_r0c2 == '0) ||
         (m_out_r1c0 == '0 && m_out_r1c1 == '0 && m_out_r1c2 == '0) ||
         (m_out_r2c0 == '0 && m_out_r2c1 == '0 && m_out_r2c2 == '0)))
        else $error("degenerate flag without a zero row");

endmodule

[src/gs3_delay.sv]
// ----------------------------------------------------------------------------
// gs3_delay
// Enabled shift line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
module gs3_delay #(
    parameter int unsigned W = 1,
    parameter int unsigned N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [N];

    // shift on every advance
    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[N-1];

endmodule

[src/gs3_proj.sv]
// ----------------------------------------------------------------------------
// gs3_proj
// Removes the projection of a working row onto one finished row: three
// multiply lanes, a merging sum, then three multiply-subtract lanes.
// ----------------------------------------------------------------------------
module gs3_proj (
    input  logic          aclk,
    input  logic          en,
    input  gs3_pkg::qrow_t q,
    input  gs3_pkg::vrow_t v,
    output gs3_pkg::vrow_t v_out
);

    localparam int unsigned PW    = gs3_pkg::PW;
    localparam int unsigned ACC_W = gs3_pkg::ACC_W;
    localparam int unsigned DW    = gs3_pkg::DW;
    localparam int unsigned VW    = gs3_pkg::VW;

    logic signed [PW-1:0]    p_reg [3];
    logic signed [PW-1:0]    m_reg [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DW-1:0]    d_reg;
    gs3_pkg::qrow_t          q1_reg, q2_reg, q3_reg;
    gs3_pkg::vrow_t          v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // lane products q.v
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= $signed(q[k]) * $signed(v[k]);
            end
            q1_reg <= q;
            v1_reg <= v;
            // merge lanes
            acc_reg <= ACC_W'(p_reg[0]) + ACC_W'(p_reg[1]) + ACC_W'(p_reg[2]);
            q2_reg  <= q1_reg;
            v2_reg  <= v1_reg;
            // coefficient
            d_reg  <= DW'(gs3_pkg::rnd_shift(acc_reg, gs3_pkg::QF_BITS));
            q3_reg <= q2_reg;
            v3_reg <= v2_reg;
            // scaled finished row
            for (int k = 0; k < 3; k++) begin
                m_reg[k] <= d_reg * $signed(q3_reg[k]);
            end
            v4_reg <= v3_reg;
            // subtract
            for (int k = 0; k < 3; k++) begin
                vo_reg[k] <= VW'(ACC_W'($signed(v4_reg[k]))
                             - gs3_pkg::rnd_shift(ACC_W'(m_reg[k]), gs3_pkg::QF_BITS));
            end
        end
    end

    assign v_out = vo_reg;

endmodule

[src/gs3_isqrt.sv]
// ----------------------------------------------------------------------------
// gs3_isqrt
// Pipelined integer square root, one result bit per stage (floor).
// ----------------------------------------------------------------------------
module gs3_isqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [gs3_pkg::SQ_IN_W-1:0]  n,
    output logic [gs3_pkg::ROOT_W-1:0]   root
);

    localparam int unsigned W  = gs3_pkg::SQ_IN_W;
    localparam int unsigned NS = gs3_pkg::ROOT_W;

    logic [W-1:0] rem_reg [NS];
    logic [W-1:0] res_reg [NS];
    logic [W-1:0] rem_in  [NS];
    logic [W-1:0] res_in  [NS];
    logic [W-1:0] rem_next [NS];
    logic [W-1:0] res_next [NS];

    assign rem_in[0] = n;
    assign res_in[0] = '0;
    for (genvar i = 1; i < NS; i++) begin : g_link
        assign rem_in[i] = rem_reg[i-1];
        assign res_in[i] = res_reg[i-1];
    end

    // one trial subtract per stage
    always_comb begin
        logic [W-1:0] bitv;
        logic [W-1:0] trial;
        for (int i = 0; i < NS; i++) begin
            bitv  = W'(1) << (W - 2 - 2 * i);
            trial = res_in[i] + bitv;
            if (rem_in[i] >= trial) begin
                rem_next[i] = rem_in[i] - trial;
                res_next[i] = (res_in[i] >> 1) + bitv;
            end else begin
                rem_next[i] = rem_in[i];
                res_next[i] = res_in[i] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                rem_reg[i] <= rem_next[i];
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign root = res_reg[NS-1][NS-1:0];

endmodule

[src/gs3_div.sv]
// ----------------------------------------------------------------------------
// gs3_div
// Pipelined restoring divider lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module gs3_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [gs3_pkg::DVD_W-1:0]   dvd,
    input  logic [gs3_pkg::ROOT_W-1:0]  dsr,
    output logic [gs3_pkg::QUO_W-1:0]   quo
);

    localparam int unsigned RW = gs3_pkg::DVD_W;
    localparam int unsigned SW = gs3_pkg::ROOT_W;
    localparam int unsigned NS = gs3_pkg::QUO_W;

    logic [RW-1:0] rem_reg [NS];
    logic [SW-1:0] dsr_reg [NS];
    logic [NS-1:0] quo_reg [NS];
    logic [RW-1:0] rem_in  [NS];
    logic [SW-1:0] dsr_in  [NS];
    logic [NS-1:0] quo_in  [NS];
    logic [RW-1:0] rem_next [NS];
    logic [NS-1:0] quo_next [NS];

    assign rem_in[0] = dvd;
    assign dsr_in[0] = dsr;
    assign quo_in[0] = '0;
    for (genvar i = 1; i < NS; i++) begin : g_link
        assign rem_in[i] = rem_reg[i-1];
        assign dsr_in[i] = dsr_reg[i-1];
        assign quo_in[i] = quo_reg[i-1];
    end

    // compare against shifted divisor, MSB first
    always_comb begin
        logic [RW-1:0] sub;
        for (int i = 0; i < NS; i++) begin
            sub = RW'(dsr_in[i]) << (NS - 1 - i);
            if (rem_in[i] >= sub) begin
                rem_next[i] = rem_in[i] - sub;
                quo_next[i] = {quo_in[i][NS-2:0], 1'b1};
            end else begin
                rem_next[i] = rem_in[i];
                quo_next[i] = {quo_in[i][NS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                rem_reg[i] <= rem_next[i];
                dsr_reg[i] <= dsr_in[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule

[src/gs3_norm.sv]
// ----------------------------------------------------------------------------
// gs3_norm
// Normalises one working row: square lanes merged into the squared norm,
// pipelined square root, then three divider lanes. A zero norm gives zeros.
// ----------------------------------------------------------------------------
module gs3_norm (
    input  logic           aclk,
    input  logic           en,
    input  gs3_pkg::vrow_t v,
    output gs3_pkg::qrow_t q,
    output logic           zero
);

    localparam int unsigned VW    = gs3_pkg::VW;
    localparam int unsigned QW    = gs3_pkg::QW;
    localparam int unsigned SQ_W  = gs3_pkg::SQ_W;
    localparam int unsigned SUM_W = gs3_pkg::SUM_W;
    localparam int unsigned N2_W  = gs3_pkg::N2_W;
    localparam int unsigned RT_W  = gs3_pkg::ROOT_W;
    localparam int unsigned DVD_W = gs3_pkg::DVD_W;
    localparam int unsigned QUO_W = gs3_pkg::QUO_W;
    localparam int unsigned SH    = gs3_pkg::QF_BITS + gs3_pkg::NORM_EXTRA;

    logic [VW-1:0]    mag_c [3];
    logic [SQ_W-1:0]  sq_reg [3];
    logic [SUM_W-1:0] n2_sum;
    logic [N2_W-1:0]  n2_reg;
    logic             zero_reg;
    gs3_pkg::vrow_t   v1_reg, v2_reg, v_d;
    logic             z_d;
    logic [RT_W-1:0]  root;
    logic [DVD_W-1:0] dvd_reg [3];
    logic [RT_W-1:0]  s_reg;
    logic [2:0]       sign_reg;
    logic             z3_reg;
    logic [QUO_W-1:0] quo [3];
    logic [2:0]       sign_d;
    logic             z4_d;
    gs3_pkg::qrow_t   q_reg;
    logic             zo_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_c[k] = gs3_pkg::mag_v(v[k]);
        end
        n2_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    // squares, then merged squared norm
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= SQ_W'(mag_c[k]) * SQ_W'(mag_c[k]);
            end
            v1_reg   <= v;
            n2_reg   <= n2_sum[N2_W-1:0];
            zero_reg <= (n2_sum == '0);
            v2_reg   <= v1_reg;
        end
    end

    gs3_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .n    ({n2_reg, {(2 * gs3_pkg::NORM_EXTRA){1'b0}}}),
        .root (root)
    );

    gs3_delay #(.W(3 * VW + 1), .N(gs3_pkg::LAT_SQRT)) u_dly_v (
        .aclk (aclk),
        .en   (en),
        .din  ({v2_reg, zero_reg}),
        .dout ({v_d, z_d})
    );

    // dividend with half-divisor rounding term
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                dvd_reg[k]  <= DVD_W'(64'(gs3_pkg::mag_v(v_d[k])) << SH)
                               + DVD_W'(root >> 1);
                sign_reg[k] <= v_d[k][VW-1];
            end
            s_reg  <= root;
            z3_reg <= z_d;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        gs3_div u_div (
            .aclk (aclk),
            .en   (en),
            .dvd  (dvd_reg[k]),
            .dsr  (s_reg),
            .quo  (quo[k])
        );
    end

    gs3_delay #(.W(4), .N(gs3_pkg::LAT_DIV)) u_dly_s (
        .aclk (aclk),
        .en   (en),
        .din  ({sign_reg, z3_reg}),
        .dout ({sign_d, z4_d})
    );

    // restore sign, force zero row
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (z4_d) begin
                    q_reg[k] <= '0;
                end else if (sign_d[k]) begin
                    q_reg[k] <= -$signed(QW'(quo[k]));
                end else begin
                    q_reg[k] <= $signed(QW'(quo[k]));
                end
            end
            zo_reg <= z4_d;
        end
    end

    assign q    = q_reg;
    assign zero = zo_reg;

endmodule

[test/gs3_checker.sv]
// ----------------------------------------------------------------------------
// gs3_checker
// Watches both channels of the 3x3 Gram-Schmidt orthonormaliser, computes the
// expected orthonormal rows for every accepted request and compares results.
// ----------------------------------------------------------------------------
module gs3_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_in [9],
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_out [9],
    input  logic               m_degenerate,
    output int                 fail_count,
    output int                 pending,
    output int                 seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] ent [9];
        logic               degen;
    } ortho_t;

    ortho_t expected_q[$];

    // Round to nearest, ties away from zero, then shift right
    function automatic longint round_shift(longint x, int sh);
        longint unsigned u;
        u = (x < 0) ? -x : x;
        u = (u + (64'd1 << (sh - 1))) >> sh;
        return (x < 0) ? -longint'(u) : longint'(u);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic ortho_t orthonormalise(logic signed [15:0] a [9]);
        ortho_t r;
        longint q [3][3];
        longint v [3];
        longint acc, d, o;
        longint unsigned n2, s, num, quo, m;
        r.degen = 0;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) v[k] = longint'(a[i*3+k]) * 256;
            // remove projections onto finished rows, using the updated row
            for (int j = 0; j < i; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += q[j][k] * v[k];
                d = round_shift(acc, 30);
                for (int k = 0; k < 3; k++) v[k] -= round_shift(d * q[j][k], 30);
            end
            n2 = 0;
            for (int k = 0; k < 3; k++) begin
                m = (v[k] < 0) ? -v[k] : v[k];
                n2 += m * m;
            end
            if (n2 == 0) begin
                r.degen = 1;
                for (int k = 0; k < 3; k++) q[i][k] = 0;
            end else begin
                s = int_sqrt(n2 << 12);
                for (int k = 0; k < 3; k++) begin
                    num = ((v[k] < 0) ? -v[k] : v[k]) << 36;
                    quo = (num + (s >> 1)) / s;
                    q[i][k] = (v[k] < 0) ? -longint'(quo) : longint'(quo);
                end
            end
        end
        for (int e = 0; e < 9; e++) begin
            o = round_shift(q[e/3][e%3], 16);
            if (o > 16384) o = 16384;
            if (o < -16384) o = -16384;
            r.ent[e] = o[15:0];
        end
        return r;
    endfunction

    // Predict on input acceptance, compare on output acceptance
    always @(posedge aclk) begin
        ortho_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            expected_q.delete();
            fail_count <= 0;
            seen <= 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_q.insert(expected_q.size(), orthonormalise(s_in));
            if (m_valid && m_ready) begin
                seen <= seen + 1;
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    for (int e = 0; e < 9; e++) begin
                        if (m_out[e] !== want.ent[e]) begin
                            $error("out_r%0dc%0d: expected %0d, got %0d",
                                   e/3, e%3, want.ent[e], m_out[e]);
                            errs++;
                        end
                    end
                    if (m_degenerate !== want.degen) begin
                        $error("degenerate: expected %0d, got %0d", want.degen, m_degenerate);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_q.size();
        end
    end
endmodule

[test/tb_gram_schmidt_orthonormalize_3x3.sv]
// ----------------------------------------------------------------------------
// tb_gram_schmidt_orthonormalize_3x3
// Drives directed and random matrices, with random gaps and output stalls,
// into the orthonormaliser; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_gram_schmidt_orthonormalize_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1400;
    localparam int LATENCY   = 210;
    localparam int MAX_CYCLES = 400000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [15:0] s_in [9];
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [15:0] m_out [9];
    logic               m_degenerate;
    int                 fail_count, pending, seen;
    int                 cycle = 0;
    int                 sent = 0;
    bit                 hold_done = 0;

    initial for (int e = 0; e < 9; e++) s_in[e] = '0;

    always #1 aclk = ~aclk;

    gram_schmidt_orthonormalize_3x3 uut (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_in_r0c0(s_in[0]), .s_in_r0c1(s_in[1]), .s_in_r0c2(s_in[2]),
        .s_in_r1c0(s_in[3]), .s_in_r1c1(s_in[4]), .s_in_r1c2(s_in[5]),
        .s_in_r2c0(s_in[6]), .s_in_r2c1(s_in[7]), .s_in_r2c2(s_in[8]),
        .m_valid, .m_ready,
        .m_out_r0c0(m_out[0]), .m_out_r0c1(m_out[1]), .m_out_r0c2(m_out[2]),
        .m_out_r1c0(m_out[3]), .m_out_r1c1(m_out[4]), .m_out_r1c2(m_out[5]),
        .m_out_r2c0(m_out[6]), .m_out_r2c1(m_out[7]), .m_out_r2c2(m_out[8]),
        .m_degenerate
    );

    gs3_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_in, .m_valid, .m_ready, .m_out,
        .m_degenerate, .fail_count, .pending, .seen
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES) begin
            $display("tb_gram_schmidt_orthonormalize_3x3 NOT OK");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one matrix request after a random gap, with no gap for the first 30 of every 200
    task automatic send_matrix(input logic signed [15:0] m [9]);
        int gap;
        gap = (sent % 200 < 30) ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        for (int e = 0; e < 9; e++) s_in[e] <= m[e];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Sink: long hold-off once, then random stalls with bursts of none
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        m_ready <= 0;
        repeat (600) @(posedge aclk);
        hold_done = 1;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall == 0) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        logic signed [15:0] m [9];
        int drained;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: identity, extremes, zero rows, dependent rows
        for (int t = 0; t < 20; t++) begin
            for (int e = 0; e < 9; e++) begin
                case (t)
                    0: m[e] = (e % 4 == 0) ? 16'sd8192 : 16'sd0;
                    1: m[e] = 16'sh7FFF;
                    2: m[e] = 16'sh8000;
                    3: m[e] = 16'sd0;
                    4: m[e] = (e < 3) ? 16'sd0 : ((e % 4 == 0) ? 16'sd8192 : 16'sd0);
                    5: m[e] = (e >= 3 && e < 6) ? 16'sd0 : ((e % 4 == 0) ? 16'sh8000 : 16'sd0);
                    6: m[e] = (e % 3 == 0) ? 16'sd100 : ((e % 3 == 1) ? 16'sd200 : -16'sd300);
                    7: m[e] = (e < 6) ? ((e % 3 == 1) ? 16'sd1 : 16'sd0) : 16'sd0;
                    8: m[e] = (e % 2) ? 16'sh7FFF : 16'sh8000;
                    9: m[e] = (e / 3 == 1) ? -m[e - 3] : ((e < 3) ? 16'sd1 << e : 16'sd3);
                    10: m[e] = (e % 3 == 0) ? 16'sd1 : 16'sd0;
                    default: m[e] = rand_entry();
                endcase
            end
            send_matrix(m);
        end

        // Random: mostly well-conditioned, some with repeated or scaled rows
        for (int n = 0; n < N_RANDOM; n++) begin
            for (int e = 0; e < 9; e++)
                m[e] = ($urandom_range(0, 1)) ? rand_entry() : 16'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                for (int k = 0; k < 3; k++) m[3 + k] = m[k];
            end
            if ($urandom_range(0, 19) == 0) begin
                for (int k = 0; k < 3; k++) m[6 + k] = m[k] >>> 1;
            end
            send_matrix(m);
        end
        s_valid <= 0;

        // Drain
        while (pending != 0 || !hold_done) @(posedge aclk);
        drained = 0;
        while (drained < 2 * LATENCY) begin
            @(posedge aclk);
            drained++;
        end
        $display("Run covered %0d matrices, %0d results checked, with random gaps and stalls.",
                 sent, seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_gram_schmidt_orthonormalize_3x3 OK");
        else
            $display("tb_gram_schmidt_orthonormalize_3x3 NOT OK");
        $finish;
    end
endmodule
